### rtl/core/lds_pkg.sv
// Package for the largest divisible subset block: value width and default capacity.
// No dependencies.
package lds_pkg;
    localparam int VALUE_W       = 31;
    localparam int MAX_ITEMS_DEF = 32;
endpackage

### rtl/core/lds_if.sv
// Valid/ready channel interfaces for the largest divisible subset block.
// Depends on lds_pkg.
interface lds_in_if;
    import lds_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last_item;
    modport source (output valid, value, last_item, input ready);
    modport sink   (input valid, value, last_item, output ready);
endinterface

interface lds_out_if;
    import lds_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] chain_value;
    logic               last_result;
    logic               overflowed;
    modport source (output valid, chain_value, last_result, overflowed, input ready);
    modport sink   (input valid, chain_value, last_result, overflowed, output ready);
endinterface

### rtl/core/lds_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module lds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### rtl/core/lds_rem.sv
// Bit-serial remainder unit: b % a, one quotient bit per cycle.
// Depends on lds_pkg.
module lds_rem
    import lds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_divisor,
    input  logic [VALUE_W-1:0] i_dividend,
    output logic               o_done,
    output logic               o_divides
);
    localparam int CW = $clog2(VALUE_W + 1);
    logic               r_busy, n_busy;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [VALUE_W-1:0] r_num, n_num, r_den;
    logic [VALUE_W:0]   r_rem, n_rem;
    logic [VALUE_W:0]   w_sh;
    logic               r_done, r_zero_div;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        w_sh   = {r_rem[VALUE_W-1:0], r_num[VALUE_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(VALUE_W);
            n_num  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_num = {r_num[VALUE_W-2:0], 1'b0};
            n_rem = (w_sh >= {1'b0, r_den}) ? w_sh - {1'b0, r_den} : w_sh;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && (r_cnt == CW'(1));
        end
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_start) begin
            r_den      <= i_divisor;
            r_zero_div <= (i_divisor == '0);
        end
    end

    // zero divides only zero; remainder by zero leaves the dividend
    assign o_done    = r_done;
    assign o_divides = (r_rem == '0);

    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_done) begin
            assert (!r_busy) else $error("remainder unit busy at done");
        end
    end
    property p_start_idle;
        @(posedge i_clk) disable iff (!i_rst_n) i_start |-> !r_busy;
    endproperty
    a_start_idle: assert property (p_start_idle) else $error("start while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_zero_div) |-> (o_divides == (r_num == '0 && r_rem == '0)))
        else $error("zero divisor rule");
endmodule

### rtl/core/largest_divisible_subset.sv
// Top level of the largest divisible subset block: load, sort, chain search, emit.
// Depends on lds_pkg, lds_if, lds_ram, lds_rem.
//
//  channel   dir  handshake     word
//  s_in      in   valid/ready   value[30:0], last_item
//  m_out     out  valid/ready   chain_value[30:0], last_result, overflowed
//
// Unmarked words load while ready is high. After the marked word the block is busy:
// insertion sort with up to n*(n-1)/2 RAM moves, then n*(n-1)/2 divisibility
// tests in the shared bit-serial remainder unit, then a best scan over the entries,
// then the chain words out.
// Reset is synchronous, active low; RAM contents need none.
// Output stalls hold the chain walk; input reopens once the last chain word is registered.
module largest_divisible_subset
    import lds_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lds_in_if.sink    s_in,
    lds_out_if.source m_out
);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    localparam logic [3:0] S_LOAD = 4'd0, S_SR = 4'd1, S_SR2 = 4'd2, S_SCMP = 4'd3,
        S_DPI = 4'd4, S_DPRD = 4'd5, S_DPJ = 4'd6, S_DPW = 4'd7, S_DPT = 4'd8,
        S_BEST = 4'd9, S_BESTC = 4'd10, S_ER = 4'd11, S_EO = 4'd12;

    logic [3:0]         r_st, n_st;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_ovf, n_ovf;
    logic [CW-1:0]      r_i, n_i, r_j, n_j;
    logic [VALUE_W-1:0] r_key, n_key, r_vi, n_vi;
    logic [CW-1:0]      r_len, n_len, r_best, n_best, r_emitted, n_emitted;
    logic [AW-1:0]      r_nxt, n_nxt, r_start, n_start;

    logic               v_we, l_we;
    logic [AW-1:0]      v_wa, v_ra, l_wa, l_ra;
    logic [VALUE_W-1:0] v_wd, v_rd;
    logic [2*CW-1:0]    l_wd, l_rd;
    logic               d_start, d_done, d_div;
    logic [VALUE_W-1:0] r_oval;
    logic               r_olast, r_oovf, r_ovalid;

    lds_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_val (
        .i_clk, .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(v_ra), .o_rdata(v_rd));
    // {chain length, successor} per sorted entry
    lds_ram #(.WIDTH(2*CW), .DEPTH(MAX_ITEMS)) u_len (
        .i_clk, .i_we(l_we), .i_waddr(l_wa), .i_wdata(l_wd),
        .i_raddr(l_ra), .o_rdata(l_rd));
    lds_rem u_rem (.i_clk, .i_rst_n, .i_start(d_start), .i_divisor(r_vi),
        .i_dividend(v_rd), .o_done(d_done), .o_divides(d_div));

    assign s_in.ready        = (r_st == S_LOAD);
    assign m_out.valid       = r_ovalid;
    assign m_out.chain_value = r_oval;
    assign m_out.last_result = r_olast;
    assign m_out.overflowed  = r_oovf;

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_ovf = r_ovf; n_i = r_i; n_j = r_j;
        n_key = r_key; n_vi = r_vi; n_len = r_len; n_nxt = r_nxt;
        n_best = r_best; n_start = r_start; n_emitted = r_emitted;
        v_we = 1'b0; v_wa = r_cnt[AW-1:0]; v_wd = s_in.value; v_ra = r_j[AW-1:0];
        l_we = 1'b0; l_wa = r_i[AW-1:0]; l_wd = {r_len, CW'(r_nxt)};
        l_ra = r_j[AW-1:0]; d_start = 1'b0;
        case (r_st)
            S_LOAD: begin
                if (s_in.valid) begin
                    if (r_cnt < CW'(MAX_ITEMS)) begin
                        v_we = 1'b1; n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_in.last_item) begin
                        n_i = CW'(1); n_st = S_SR;
                    end
                end
            end
            // insertion sort: r_i outer, r_j hole position
            S_SR: begin
                if (r_i >= r_cnt) begin
                    n_i = r_cnt; n_st = S_DPI;
                end else begin
                    v_ra = r_i[AW-1:0]; n_j = r_i; n_st = S_SR2;
                end
            end
            S_SR2: begin
                n_key = v_rd; v_ra = AW'(r_j - 1'b1); n_st = S_SCMP;
            end
            S_SCMP: begin
                // v_rd holds entry j-1; meaningless once j reaches zero
                if (r_j != '0 && v_rd > r_key) begin
                    v_we = 1'b1; v_wa = r_j[AW-1:0]; v_wd = v_rd;
                    n_j = r_j - 1'b1;
                    v_ra = AW'(r_j - CW'(2));
                end else begin
                    v_we = 1'b1; v_wa = r_j[AW-1:0]; v_wd = r_key;
                    n_i = r_i + 1'b1; n_st = S_SR;
                end
            end
            // DP from the top index down
            S_DPI: begin
                if (r_i == '0) begin
                    n_best = '0; n_start = '0; n_st = S_BEST;
                end else begin
                    n_i = r_i - 1'b1; v_ra = AW'(r_i - 1'b1);
                    n_len = CW'(1); n_nxt = AW'(r_i - 1'b1);
                    n_j = r_i; n_st = S_DPRD;
                end
            end
            S_DPRD: begin
                n_vi = v_rd; n_st = S_DPJ;
            end
            S_DPJ: begin
                if (r_j >= r_cnt) begin
                    l_we = 1'b1; n_st = S_DPI;
                end else begin
                    n_st = S_DPW;
                end
            end
            S_DPW: begin
                d_start = 1'b1; n_st = S_DPT;
            end
            S_DPT: begin
                if (d_done) begin
                    if (d_div && (l_rd[2*CW-1:CW] + CW'(1) > r_len)) begin
                        n_len = l_rd[2*CW-1:CW] + CW'(1); n_nxt = r_j[AW-1:0];
                    end
                    n_j = r_j + 1'b1; n_st = S_DPJ;
                end
            end
            S_BEST: begin
                l_ra = r_i[AW-1:0]; n_st = S_BESTC;
            end
            S_BESTC: begin
                if (l_rd[2*CW-1:CW] > r_best) begin
                    n_best = l_rd[2*CW-1:CW]; n_start = r_i[AW-1:0];
                end
                if (r_i + 1'b1 >= r_cnt) begin
                    n_j = CW'(n_start); n_emitted = '0; n_st = S_ER;
                end else begin
                    n_i = r_i + 1'b1; n_st = S_BEST;
                end
            end
            S_ER: begin
                v_ra = r_j[AW-1:0]; l_ra = r_j[AW-1:0]; n_st = S_EO;
            end
            S_EO: begin
                if (!r_ovalid || m_out.ready) begin
                    n_emitted = r_emitted + 1'b1;
                    n_j = CW'(l_rd[AW-1:0]);
                    n_st = (r_emitted + 1'b1 == r_best) ? S_LOAD : S_ER;
                    if (r_emitted + 1'b1 == r_best) begin
                        n_cnt = '0; n_ovf = 1'b0;
                    end
                end
            end
            default: n_st = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD; r_cnt <= '0; r_ovf <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_ovf <= n_ovf;
            if (r_st == S_EO && (!r_ovalid || m_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (m_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (r_st == S_EO && (!r_ovalid || m_out.ready)) begin
            r_oval  <= v_rd;
            r_olast <= (r_emitted + 1'b1 == r_best);
            r_oovf  <= r_ovf;
        end
        r_i <= n_i; r_j <= n_j; r_key <= n_key; r_vi <= n_vi; r_len <= n_len;
        r_nxt <= n_nxt; r_best <= n_best; r_start <= n_start;
        r_emitted <= n_emitted;
    end

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.ready |-> (r_emitted == r_best || r_st == S_LOAD)) else $error("ready");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ITEMS)) else $error("count above capacity");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_EO) |-> (r_emitted < r_best)) else $error("emit past chain");
endmodule
